[sv/ppa_pkg.sv]
// ----------------------------------------------------------------------------
// Physical page allocator package
// Request and response payloads, request modes, status codes and
// configuration register indexes shared by the allocator files.
// ----------------------------------------------------------------------------
package ppa_pkg;

  // Default number of pages the free map can hold
  localparam int DEFAULT_MAX_PAGES = 256;

  // Request modes
  localparam logic [2:0] MODE_INIT   = 3'd0;
  localparam logic [2:0] MODE_ALLOC  = 3'd1;
  localparam logic [2:0] MODE_AT     = 3'd2;
  localparam logic [2:0] MODE_FREE   = 3'd3;
  localparam logic [2:0] MODE_CONTIG = 3'd4;

  // Response status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_OOM     = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_DOUBLE  = 3'd3;
  localparam logic [2:0] ST_NOTFREE = 3'd4;

  // Configuration registers
  localparam int         CFG_IDX_W = 1;
  localparam int         CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_USABLE = 1'b1;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] page_index;
    logic [8:0] page_run_length;
  } req_t;

  typedef struct packed {
    logic [7:0]  granted_page;
    logic [2:0]  status;
    logic [8:0]  free_pages;
    logic [8:0]  longest_free_run;
    logic [31:0] oom_events;
  } rsp_t;

endpackage

[sv/ppa_stream_if.sv]
// ----------------------------------------------------------------------------
// Allocator stream interface
// Valid/ready channel carrying one request or response payload.
// ----------------------------------------------------------------------------
interface ppa_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/physical_page_allocator.sv]
// ----------------------------------------------------------------------------
// Physical page allocator
// Free-page map with init, highest-page alloc, named alloc, free and first-fit
// contiguous alloc; every response reports free count and longest free run.
// ----------------------------------------------------------------------------
// The allocator handles one request at a time and is not ready while a
// request is in flight. The free map lives in flip-flops and is walked by a
// single eight-page chunk unit under a small sequencer. Each request is
// captured in S_IDLE and set up in S_EXEC, then runs its operation pass, then
// one statistics pass that counts free pages and the longest free run:
//   alloc-at, free, invalid requests : statistics pass only
//   alloc highest                    : downward search, then statistics
//   init                             : rewrite of every chunk, then statistics
//   contiguous alloc                 : upward search, then a clear of the run
//                                      on a hit, then statistics
// A finished response is held in an output register; the next request is
// taken while it waits, and the sequencer only stalls at the end of the
// statistics pass if the previous response has still not been taken.
// Configuration writes are taken at any time but are meant for idle periods.
module physical_page_allocator #(
  parameter int MAX_PAGES = ppa_pkg::DEFAULT_MAX_PAGES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ppa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ppa_pkg::CFG_DATA_W-1:0]   cfg_data,
  ppa_stream_if.sink                       req,
  ppa_stream_if.source                     rsp
);
  import ppa_pkg::*;

  // Chunk geometry: the map is padded to a power of two number of chunks
  localparam int CHUNKS    = (MAX_PAGES + 7) / 8;
  localparam int CW        = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int PAW       = CW + 3;
  localparam int MAPW      = 1 << PAW;
  localparam int WW        = (PAW + 1 > 9) ? PAW + 1 : 9;
  localparam logic [CW-1:0] LAST_CHUNK = CW'(CHUNKS - 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_INIT  = 7'b0000100,
    S_HIGH  = 7'b0001000,
    S_RUN   = 7'b0010000,
    S_CLEAR = 7'b0100000,
    S_STATS = 7'b1000000
  } state_t;

  state_t          state;
  logic [MAPW-1:0] free_map;
  logic [CW-1:0]   chunk;
  logic [2:0]      mode;
  logic [WW-1:0]   idx;
  logic [WW-1:0]   run_need;
  logic [WW-1:0]   lim;
  logic [2:0]      status;
  logic [WW-1:0]   granted;
  logic [31:0]     oom_counter;
  logic [WW-1:0]   run_len;
  logic [WW-1:0]   run_base;
  logic [WW-1:0]   run_end;
  logic [WW-1:0]   cnt;
  logic [WW-1:0]   best;
  logic [8:0]      pages_in_use;
  logic [8:0]      first_usable_page;
  logic            rsp_valid;
  rsp_t            rsp_data;

  // Chunk unit outputs
  logic [7:0]      chunk_bits;
  logic [7:0]      live;
  logic [7:0]      init_bits;
  logic [7:0]      clear_bits;
  logic            hi_hit;
  logic [2:0]      hi_pos;
  logic            r_found;
  logic [WW-1:0]   r_len;
  logic [WW-1:0]   r_start;
  logic [WW-1:0]   r_end;
  logic [WW-1:0]   s_cnt;
  logic [WW-1:0]   s_run;
  logic [WW-1:0]   s_best;
  logic [WW-1:0]   idx_bit_page;
  logic            idx_free;
  logic            rsp_room;
  logic            rsp_load;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;
  assign rsp_room  = !rsp_valid || rsp.ready;
  // Publish at the last statistics chunk once the output register is free
  assign rsp_load  = (state == S_STATS) && (chunk == LAST_CHUNK) && rsp_room;

  assign chunk_bits   = free_map[{chunk, 3'b000} +: 8];
  assign idx_bit_page = idx;
  assign idx_free     = free_map[idx_bit_page[PAW-1:0]];

  // Chunk unit: one eight-page slice of the map per cycle
  always_comb begin
    logic [WW-1:0] page;
    hi_hit  = 1'b0;
    hi_pos  = 3'd0;
    r_found = 1'b0;
    r_len   = run_len;
    r_start = run_base;
    r_end   = run_end;
    s_cnt   = cnt;
    s_run   = run_len;
    s_best  = best;
    for (int j = 0; j < 8; j++) begin
      page          = WW'({chunk, 3'(j)});
      live[j]       = chunk_bits[j] && (page < lim);
      init_bits[j]  = (page >= WW'(first_usable_page)) && (page < lim);
      clear_bits[j] = chunk_bits[j] && !((page >= run_base) && (page <= run_end));
      // Highest free page in the slice: later hits win
      if (live[j]) begin
        hi_hit = 1'b1;
        hi_pos = 3'(j);
      end
      // First-fit run tracking, frozen once the run is long enough
      if (!r_found) begin
        if (live[j]) begin
          if (r_len == '0) begin
            r_start = page;
          end
          r_len = r_len + 1'b1;
          if (r_len >= run_need) begin
            r_found = 1'b1;
            r_end   = page;
          end
        end else begin
          r_len = '0;
        end
      end
      // Free count and longest run
      if (live[j]) begin
        s_cnt = s_cnt + 1'b1;
        s_run = s_run + 1'b1;
        if (s_run > s_best) begin
          s_best = s_run;
        end
      end else begin
        s_run = '0;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pages_in_use      <= 9'd256;
      first_usable_page <= 9'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PAGES_IN_USE: pages_in_use      <= cfg_data;
        CFG_FIRST_USABLE: first_usable_page <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      free_map    <= '0;
      oom_counter <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      // Drop the response once taken unless a new one is loaded below
      if (rsp_valid && rsp.ready && !rsp_load) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            mode     <= req.data.mode;
            idx      <= WW'(req.data.page_index);
            run_need <= WW'(req.data.page_run_length);
            lim      <= (WW'(pages_in_use) < WW'(MAX_PAGES)) ?
                        WW'(pages_in_use) : WW'(MAX_PAGES);
            state    <= S_EXEC;
          end
        end

        S_EXEC: begin
          cnt     <= '0;
          best    <= '0;
          run_len <= '0;
          case (mode)
            MODE_INIT: begin
              status  <= ST_OK;
              granted <= '0;
              chunk   <= '0;
              state   <= S_INIT;
            end
            MODE_ALLOC: begin
              status  <= ST_OK;
              granted <= '0;
              chunk   <= LAST_CHUNK;
              state   <= S_HIGH;
            end
            MODE_AT: begin
              chunk <= '0;
              state <= S_STATS;
              if (idx >= lim) begin
                status  <= ST_INVALID;
                granted <= '0;
              end else if (!idx_free) begin
                status  <= ST_NOTFREE;
                granted <= '0;
              end else begin
                free_map[idx_bit_page[PAW-1:0]] <= 1'b0;
                status  <= ST_OK;
                granted <= idx;
              end
            end
            MODE_FREE: begin
              granted <= '0;
              chunk   <= '0;
              state   <= S_STATS;
              if (idx >= lim) begin
                status <= ST_INVALID;
              end else if (idx_free) begin
                status <= ST_DOUBLE;
              end else begin
                free_map[idx_bit_page[PAW-1:0]] <= 1'b1;
                status <= ST_OK;
              end
            end
            MODE_CONTIG: begin
              granted <= '0;
              if (run_need == '0) begin
                status <= ST_INVALID;
                chunk  <= '0;
                state  <= S_STATS;
              end else if (run_need == WW'(1)) begin
                // A single page behaves as a plain alloc
                status <= ST_OK;
                chunk  <= LAST_CHUNK;
                state  <= S_HIGH;
              end else begin
                status <= ST_OK;
                chunk  <= '0;
                state  <= S_RUN;
              end
            end
            default: begin
              status  <= ST_INVALID;
              granted <= '0;
              chunk   <= '0;
              state   <= S_STATS;
            end
          endcase
        end

        S_INIT: begin
          // Rewrite the whole map: free only first_usable..limit-1
          free_map[{chunk, 3'b000} +: 8] <= init_bits;
          if (chunk == LAST_CHUNK) begin
            chunk <= '0;
            state <= S_STATS;
          end else begin
            chunk <= chunk + 1'b1;
          end
        end

        S_HIGH: begin
          // Walk down from the top chunk
          if (hi_hit) begin
            free_map[{chunk, hi_pos}] <= 1'b0;
            granted <= WW'({chunk, hi_pos});
            chunk   <= '0;
            state   <= S_STATS;
          end else if (chunk == '0) begin
            oom_counter <= oom_counter + 32'd1;
            status      <= ST_OOM;
            state       <= S_STATS;
          end else begin
            chunk <= chunk - 1'b1;
          end
        end

        S_RUN: begin
          // Walk up looking for the lowest long enough run
          if (r_found) begin
            run_base <= r_start;
            run_end  <= r_end;
            granted  <= r_start;
            chunk    <= r_start[PAW-1:3];
            state    <= S_CLEAR;
          end else if (chunk == LAST_CHUNK) begin
            status  <= ST_OOM;
            chunk   <= '0;
            run_len <= '0;
            state   <= S_STATS;
          end else begin
            run_len  <= r_len;
            run_base <= r_start;
            chunk    <= chunk + 1'b1;
          end
        end

        S_CLEAR: begin
          // Claim the run chunk by chunk
          free_map[{chunk, 3'b000} +: 8] <= clear_bits;
          if (chunk == run_end[PAW-1:3]) begin
            chunk   <= '0;
            run_len <= '0;
            state   <= S_STATS;
          end else begin
            chunk <= chunk + 1'b1;
          end
        end

        S_STATS: begin
          if (chunk != LAST_CHUNK) begin
            cnt     <= s_cnt;
            best    <= s_best;
            run_len <= s_run;
            chunk   <= chunk + 1'b1;
          end else if (rsp_room) begin
            // Last chunk: publish the response; hold here while it is blocked
            rsp_data.granted_page     <= 8'(granted);
            rsp_data.status           <= status;
            rsp_data.free_pages       <= 9'(s_cnt);
            rsp_data.longest_free_run <= 9'(s_best);
            rsp_data.oom_events       <= oom_counter;
            rsp_valid                 <= 1'b1;
            state                     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[bench/physical_page_allocator_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Physical page allocator testbench
// Drives init, alloc, alloc-at, free and contiguous requests through the
// request channel under random bursts and response stalls. A shadow free map
// predicts every response, and each response is checked field by field.
// ----------------------------------------------------------------------------
module physical_page_allocator_test;
  import ppa_pkg::*;

  localparam int PAGES           = DEFAULT_MAX_PAGES;
  localparam int RANDOM_ITEMS    = 1550;
  localparam int PHASES          = 12;
  localparam int IDLE_LIMIT      = 5000;
  // Room for one slow request: setup plus a search, a clear and a statistics pass
  localparam int SETTLE_CYCLES   = 120;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int BACKLOG_ITEMS   = 8;
  localparam logic [2:0] MODE_LAST_UNUSED = 3'd7;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ppa_stream_if #(.payload_t(req_t)) req_ch ();
  ppa_stream_if #(.payload_t(rsp_t)) rsp_ch ();

  physical_page_allocator #(.MAX_PAGES(PAGES)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Shadow copy of the allocator: free map, OOM counter and both registers
  logic [PAGES-1:0] shadow_free;
  logic [31:0]      shadow_oom_events;
  logic [8:0]       page_count_reg;
  logic [8:0]       first_usable_reg;

  // Responses still owed by the allocator, oldest first
  rsp_t expected_rsp[$];

  int error_count = 0;
  int hold_cycles = 0;
  int burst_left  = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shadow allocator
  // --------------------------------------------------------------------------

  // Pages at or above the configured count are invisible to every request.
  function automatic int page_limit();
    return (int'(page_count_reg) < PAGES) ? int'(page_count_reg) : PAGES;
  endfunction

  // Take the highest free page; a miss counts as an out-of-memory event.
  task automatic take_highest_page(input int lim, output bit ok, output logic [7:0] pg);
    int i;
    ok = 1'b0;
    pg = '0;
    for (i = lim - 1; i >= 0 && !ok; i--) begin
      if (shadow_free[i]) begin
        shadow_free[i] = 1'b0;
        pg = i[7:0];
        ok = 1'b1;
      end
    end
    if (!ok) shadow_oom_events++;
  endtask

  // First fit: claim the lowest run of n free pages. A miss is not counted.
  task automatic take_first_run(input int lim, input int n, output bit ok,
                                output logic [7:0] pg);
    int i;
    int k;
    int start;
    int len;
    ok = 1'b0;
    pg = '0;
    start = 0;
    len = 0;
    for (i = 0; i < lim && !ok; i++) begin
      if (shadow_free[i]) begin
        if (len == 0) start = i;
        len++;
        if (len >= n) begin
          for (k = start; k <= i; k++) shadow_free[k] = 1'b0;
          pg = start[7:0];
          ok = 1'b1;
        end
      end else begin
        len = 0;
      end
    end
  endtask

  // Apply one request to the shadow map and build the response it must give.
  task automatic predict_response(input req_t r, output rsp_t e);
    int         lim;
    int         i;
    int         cnt;
    int         run;
    int         best;
    bit         ok;
    logic [7:0] pg;
    lim = page_limit();
    e = '0;
    e.status = ST_OK;
    case (r.mode)
      MODE_INIT: begin
        // Init wipes the whole map, hidden pages included, then frees the window.
        shadow_free = '0;
        for (i = int'(first_usable_reg); i < lim; i++) shadow_free[i] = 1'b1;
      end
      MODE_ALLOC: begin
        take_highest_page(lim, ok, pg);
        if (ok) e.granted_page = pg;
        else e.status = ST_OOM;
      end
      MODE_AT: begin
        if (int'(r.page_index) >= lim) begin
          e.status = ST_INVALID;
        end else if (!shadow_free[r.page_index]) begin
          e.status = ST_NOTFREE;
        end else begin
          shadow_free[r.page_index] = 1'b0;
          e.granted_page = r.page_index;
        end
      end
      MODE_FREE: begin
        if (int'(r.page_index) >= lim) e.status = ST_INVALID;
        else if (shadow_free[r.page_index]) e.status = ST_DOUBLE;
        else shadow_free[r.page_index] = 1'b1;
      end
      MODE_CONTIG: begin
        if (r.page_run_length == '0) begin
          e.status = ST_INVALID;
        end else begin
          // A run of one behaves as a plain alloc, OOM counting included.
          if (r.page_run_length == 9'd1) take_highest_page(lim, ok, pg);
          else take_first_run(lim, int'(r.page_run_length), ok, pg);
          if (ok) e.granted_page = pg;
          else e.status = ST_OOM;
        end
      end
      default: e.status = ST_INVALID;
    endcase
    cnt = 0;
    run = 0;
    best = 0;
    for (i = 0; i < lim; i++) begin
      if (shadow_free[i]) begin
        cnt++;
        run++;
        if (run > best) best = run;
      end else begin
        run = 0;
      end
    end
    e.free_pages = cnt[8:0];
    e.longest_free_run = best[8:0];
    e.oom_events = shadow_oom_events;
  endtask

  // --------------------------------------------------------------------------
  // Monitors
  // --------------------------------------------------------------------------

  // Predict at the edge where the request is taken, so the shadow map moves in
  // step with the allocator.
  always @(posedge clk) begin : request_monitor
    rsp_t e;
    if (!rst && req_ch.valid && req_ch.ready) begin
      predict_response(req_ch.data, e);
      expected_rsp.push_back(e);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : response_checker
    rsp_t e;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_rsp.size() == 0) begin
        error_count++;
        $display("%0t: response with no request outstanding, expected none, got page %0d status %0d",
                 $time, rsp_ch.data.granted_page, rsp_ch.data.status);
      end else begin
        e = expected_rsp.pop_front();
        check_field("granted_page", e.granted_page, rsp_ch.data.granted_page);
        check_field("status", e.status, rsp_ch.data.status);
        check_field("free_pages", e.free_pages, rsp_ch.data.free_pages);
        check_field("longest_free_run", e.longest_free_run, rsp_ch.data.longest_free_run);
        check_field("oom_events", e.oom_events, rsp_ch.data.oom_events);
      end
    end
  end

  // Response side: stall on a repeating 16-bit pattern that is redrawn when the
  // epoch counter wraps; an all-ones pattern gives stretches with no stall at all. A
  // hold-off request from the main sequence overrides the pattern.
  initial begin : response_receiver
    logic [15:0] pattern;
    int          pos;
    int          epoch;
    rsp_ch.ready = 1'b0;
    pattern = '1;
    pos = 0;
    epoch = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        rsp_ch.ready <= pattern[pos];
        pos = (pos + 1) % 16;
        epoch++;
        if (epoch == 200) begin
          epoch = 0;
          // Keep one ready slot per period so a stall never lasts a whole period.
          pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
        end
      end
    end
  end

  // End the run when neither channel has moved for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    @(negedge rst);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle = 0;
      else idle++;
    end
    $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
    $display("physical_page_allocator_test: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Insert a gap, which may be empty, at the end of each burst; bursts and gaps are drawn at random.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: gap = 0;
        9:          gap = $urandom_range(30, 60);
        default:    gap = $urandom_range(1, 10);
      endcase
      if (gap > 0) begin
        @(negedge clk);
        req_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Offer one request and hold it until it is taken. Valid stays high so a
  // back-to-back request follows without a bubble.
  task automatic send_req(input req_t r);
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    do @(posedge clk); while (!req_ch.ready);
    pace_sender();
  endtask

  task automatic send_op(input logic [2:0] mode, input int idx, input int len);
    req_t r;
    r.mode = mode;
    r.page_index = idx[7:0];
    r.page_run_length = len[8:0];
    send_req(r);
  endtask

  // Drop valid and wait until every outstanding response has been taken.
  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [8:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    if (idx == CFG_PAGES_IN_USE) page_count_reg = value;
    else first_usable_reg = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Registers change only once the allocator has gone quiet.
  task automatic configure(input logic [8:0] pages, input logic [8:0] first);
    drain();
    write_reg(CFG_PAGES_IN_USE, pages);
    write_reg(CFG_FIRST_USABLE, first);
  endtask

  // Mostly well-formed traffic aimed at the managed window, with some noise:
  // out-of-window pages, zero and oversized runs, unused modes.
  function automatic req_t random_request();
    req_t r;
    int   lim;
    int   pick;
    lim = page_limit();
    r.mode = MODE_ALLOC;
    r.page_index = 8'($urandom_range(0, 255));
    r.page_run_length = 9'($urandom_range(0, 511));
    pick = $urandom_range(0, 99);
    if (pick < 3) r.mode = MODE_INIT;
    else if (pick < 28) r.mode = MODE_ALLOC;
    else if (pick < 43) r.mode = MODE_AT;
    else if (pick < 68) r.mode = MODE_FREE;
    else if (pick < 96) r.mode = MODE_CONTIG;
    else r.mode = 3'($urandom_range(0, MODE_LAST_UNUSED));
    if ((r.mode == MODE_AT || r.mode == MODE_FREE) && lim > 0 && $urandom_range(0, 3) != 0)
      r.page_index = 8'($urandom_range(0, lim - 1));
    if (r.mode == MODE_CONTIG) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) r.page_run_length = '0;
      else if (pick < 70) r.page_run_length = 9'($urandom_range(1, 8));
      else if (pick < 90) r.page_run_length = 9'($urandom_range(9, 64));
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Out of reset nothing is free: alloc misses, free and alloc-at work on
  // single pages, unused modes are rejected.
  task automatic test_empty_map();
    int m;
    send_op(MODE_ALLOC, 0, 0);
    send_op(MODE_CONTIG, 255, 1);
    send_op(MODE_CONTIG, 0, 0);
    send_op(MODE_CONTIG, 0, 5);
    send_op(MODE_FREE, 255, 0);
    send_op(MODE_FREE, 255, 0);
    send_op(MODE_AT, 255, 0);
    send_op(MODE_AT, 255, 0);
    for (m = int'(MODE_CONTIG) + 1; m <= int'(MODE_LAST_UNUSED); m++) send_op(m[2:0], 0, 511);
  endtask

  // Full map: one run takes every page, then oversized and too-long runs miss.
  task automatic test_full_map_runs();
    send_op(MODE_INIT, 0, 0);
    send_op(MODE_CONTIG, 0, PAGES);
    send_op(MODE_FREE, 0, 0);
    send_op(MODE_FREE, 128, 0);
    send_op(MODE_CONTIG, 0, 2);
    send_op(MODE_CONTIG, 0, 511);
    send_op(MODE_CONTIG, 0, 1);
    send_op(MODE_ALLOC, 0, 0);
  endtask

  // Window edges: reserved pages below first usable, out-of-range pages, a
  // shrink after init that hides pages, and a grow that shows them again.
  task automatic test_page_window();
    configure(9'd100, 9'd10);
    send_op(MODE_INIT, 0, 0);
    send_op(MODE_AT, 9, 0);
    send_op(MODE_AT, 100, 0);
    send_op(MODE_FREE, 200, 0);
    configure(9'd40, 9'd10);
    send_op(MODE_ALLOC, 0, 0);
    configure(9'd256, 9'd10);
    send_op(MODE_ALLOC, 0, 0);
    configure(9'd0, 9'd511);
    send_op(MODE_INIT, 0, 0);
    configure(9'd511, 9'd511);
    send_op(MODE_INIT, 0, 0);
    send_op(MODE_FREE, 255, 0);
  endtask

  // Hold the response side off while requests keep coming, so the output
  // register fills and the allocator stops taking requests.
  task automatic test_backpressure();
    int k;
    configure(9'd256, 9'd0);
    send_op(MODE_INIT, 0, 0);
    drain();
    hold_cycles = HOLD_OFF_CYCLES;
    for (k = 0; k < BACKLOG_ITEMS; k++) send_op(MODE_ALLOC, k, k);
  endtask

  // Random traffic over a sweep of register settings, extremes first.
  task automatic test_random_traffic();
    int         phase;
    int         k;
    logic [8:0] pages;
    logic [8:0] first;
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       begin pages = 9'd256; first = 9'd0;   end
        1:       begin pages = 9'd256; first = 9'd255; end
        2:       begin pages = 9'd0;   first = 9'd0;   end
        3:       begin pages = 9'd1;   first = 9'd0;   end
        4:       begin pages = 9'd2;   first = 9'd1;   end
        5:       begin pages = 9'd511; first = 9'd0;   end
        6:       begin pages = 9'd64;  first = 9'd16;  end
        7:       begin pages = 9'd256; first = 9'd256; end
        8:       begin pages = 9'd100; first = 9'd511; end
        default: begin
          pages = 9'($urandom_range(0, 300));
          first = 9'($urandom_range(0, pages));
        end
      endcase
      configure(pages, first);
      // Skip init now and then to keep map bits from an older page count.
      if (phase == 0 || $urandom_range(0, 3) != 0) send_op(MODE_INIT, 0, 0);
      for (k = 0; k < RANDOM_ITEMS / PHASES; k++) begin
        // Pause the sender until the allocator has answered everything.
        if ($urandom_range(0, 99) == 0) drain();
        send_req(random_request());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_sequence
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_PAGES_IN_USE;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    shadow_free = '0;
    shadow_oom_events = '0;
    page_count_reg = 9'd256;
    first_usable_reg = 9'd0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_map();
    test_full_map_runs();
    test_page_window();
    test_backpressure();
    test_random_traffic();

    // Wait for the last responses, then watch for strays.
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_rsp.size() == 0) begin
      $display("physical_page_allocator_test: done, clean");
    end else begin
      $display("physical_page_allocator_test: done, errors");
    end
    $finish;
  end

endmodule
